### sv/mhs_pkg.sv
package mhs_pkg;

    localparam int DEF_HASH_COUNT = 64;
    localparam int SIG_IDX_W      = 6;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;

    localparam logic [WORD_W-1:0] MIX_MUL = 32'h85eb_ca6b;
    localparam logic [WORD_W-1:0] FIN_MUL = 32'hc2b2_ae35;
    localparam int ROT_LEFT  = 13;
    localparam int FIN_SHIFT_A = 13;
    localparam int FIN_SHIFT_B = 16;

    typedef enum logic [1:0] {
        ACT_WRITE_SEED = 2'd0,
        ACT_CLEAR_SIG  = 2'd1,
        ACT_BYTE       = 2'd2,
        ACT_READ_SIG   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BYTE,
        ST_READ,
        ST_DRAIN
    } state_t;

endpackage

### sv/minhash_signature_engine_core.sv
// minhash signature engine: seeds, running hashes and signature minima sit in
// three simple dual-port memories indexed by hash number. a seed write or a
// signature clear is done when it is accepted and busy stays low. a shingle
// byte walks the hash memory one entry per cycle through a four-stage read,
// fold, finalize and write-back pipe, and busy holds until the pipe drains. a
// readout walks the signature memory the same way and puts one word per
// cycle on sig_index, sig_value and last, marked by strobe, for HASH_COUNT
// consecutive words, and busy holds until the last word is out. the
// receiver must take every word in the cycle it is shown, there is no hold-off.
module minhash_signature_engine_core #(
    parameter int HASH_COUNT = mhs_pkg::DEF_HASH_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mhs_pkg::action_t              action,
    input  logic [mhs_pkg::SIG_IDX_W-1:0] seed_index,
    input  logic [mhs_pkg::WORD_W-1:0]    seed_value,
    input  logic [mhs_pkg::BYTE_W-1:0]    text_byte,
    input  logic                          last_byte,
    output logic                          strobe,
    output logic [mhs_pkg::SIG_IDX_W-1:0] sig_index,
    output logic [mhs_pkg::WORD_W-1:0]    sig_value,
    output logic                          last
);
    import mhs_pkg::*;

    localparam int IDX_W = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_COUNT - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             at_start_reg, at_start_next;
    logic             pass_start_reg;
    logic             pass_fin_reg;
    logic [BYTE_W-1:0] pass_byte_reg;

    logic accept;
    logic issue_byte;
    logic issue_read;
    logic issue_last;

    logic [WORD_W-1:0] seed_mem [HASH_COUNT];
    logic [WORD_W-1:0] hash_mem [HASH_COUNT];
    logic [WORD_W-1:0] sig_mem  [HASH_COUNT];
    logic [HASH_COUNT-1:0] sig_vld_reg;

    logic [WORD_W-1:0] seed_rd_reg, hash_rd_reg, sig_rd_reg;
    logic              sig_rd_vld_reg;

    logic             v1_reg, r1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic             v2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [WORD_W-1:0] h1_reg, sig2_reg;
    logic             v3_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [WORD_W-1:0] f1_reg, sig3_reg;

    logic [WORD_W-1:0] h_sel, h_x, h_rot, h1_next;
    logic [WORD_W-1:0] sig1_val;
    logic [WORD_W-1:0] f0, f1_next, f_fin;
    logic              seed_wr_en, sig_wr_en, clear_en;

    assign accept     = start && !busy;
    assign seed_wr_en = accept && (action == ACT_WRITE_SEED)
                        && ({1'b0, seed_index} < (SIG_IDX_W + 1)'(HASH_COUNT));
    assign clear_en   = accept && (action == ACT_CLEAR_SIG);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_BYTE)
                    state_next = ST_BYTE;
                else if (accept && action == ACT_READ_SIG)
                    state_next = ST_READ;
            end
            ST_BYTE, ST_READ:
            begin
                if (cnt_reg == LAST_IDX)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !r1_reg && !v2_reg && !v3_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy       = 1'b1;
        issue_byte = 1'b0;
        issue_read = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_BYTE:  issue_byte = 1'b1;
            ST_READ:  issue_read = 1'b1;
            ST_DRAIN: busy = 1'b1;
            default:  busy = 1'b1;
        endcase
        issue_last = (issue_byte || issue_read) && (cnt_reg == LAST_IDX);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = '0;
        else if ((issue_byte || issue_read) && !issue_last)
            cnt_next = cnt_reg + 1'b1;
    end

    always_comb
    begin
        at_start_next = at_start_reg;
        if (clear_en)
            at_start_next = 1'b1;
        else if (accept && action == ACT_BYTE)
            at_start_next = last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            at_start_reg <= 1'b1;
            v1_reg       <= 1'b0;
            r1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            at_start_reg <= at_start_next;
            v1_reg       <= issue_byte;
            r1_reg       <= issue_read;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
        end
    end

    // operands held for the whole pass
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_BYTE)
        begin
            pass_start_reg <= at_start_reg;
            pass_fin_reg   <= last_byte;
            pass_byte_reg  <= text_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_wr_en)
            seed_mem[seed_index[IDX_W-1:0]] <= seed_value;
        seed_rd_reg <= seed_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
            hash_mem[idx2_reg] <= h1_reg;
        hash_rd_reg <= hash_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sig_wr_en)
            sig_mem[idx3_reg] <= f_fin;
        sig_rd_reg <= sig_mem[cnt_reg];
    end

    // entries with a clear valid bit read as all ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sig_vld_reg <= '0;
        else if (clear_en)
            sig_vld_reg <= '0;
        else if (sig_wr_en)
            sig_vld_reg[idx3_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        sig_rd_vld_reg <= sig_vld_reg[cnt_reg];
        idx1_reg       <= cnt_reg;
    end

    // fold one byte: xor sign-extended byte, rotate, multiply
    always_comb
    begin
        h_sel    = pass_start_reg ? seed_rd_reg : hash_rd_reg;
        h_x      = h_sel ^ {{(WORD_W - BYTE_W){pass_byte_reg[BYTE_W-1]}}, pass_byte_reg};
        h_rot    = (h_x << ROT_LEFT) | (h_x >> (WORD_W - ROT_LEFT));
        h1_next  = h_rot * MIX_MUL;
        sig1_val = sig_rd_vld_reg ? sig_rd_reg : '1;
    end

    always_ff @(posedge clk)
    begin
        idx2_reg <= idx1_reg;
        h1_reg   <= h1_next;
        sig2_reg <= sig1_val;
    end

    always_comb
    begin
        f0      = h1_reg ^ (h1_reg >> FIN_SHIFT_A);
        f1_next = f0 * FIN_MUL;
    end

    always_ff @(posedge clk)
    begin
        idx3_reg <= idx2_reg;
        f1_reg   <= f1_next;
        sig3_reg <= sig2_reg;
    end

    always_comb
    begin
        f_fin     = f1_reg ^ (f1_reg >> FIN_SHIFT_B);
        sig_wr_en = v3_reg && pass_fin_reg && (f_fin < sig3_reg);
    end

    assign strobe    = r1_reg;
    assign sig_index = SIG_IDX_W'(idx1_reg);
    assign sig_value = sig1_val;
    assign last      = (idx1_reg == LAST_IDX);

endmodule

### sv/mhs_checker.sv
module mhs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input mhs_pkg::action_t              action,
    input logic                          strobe,
    input logic [mhs_pkg::SIG_IDX_W-1:0] sig_index,
    input logic                          last
);
    import mhs_pkg::*;

    // readout words appear only inside a busy window
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("readout word outside busy window");

    // readout starts at index zero
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> (sig_index == '0))
        else $error("readout does not start at index zero");

    // words run back to back with rising index until last
    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && sig_index == $past(sig_index) + 1'b1))
        else $error("readout word missing or out of order");

    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("readout word after last");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_READ_SIG || action == ACT_BYTE)) |=> busy)
        else $error("pass accepted but block not busy");

endmodule

bind minhash_signature_engine_core mhs_checker u_mhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .strobe    (strobe),
    .sig_index (sig_index),
    .last      (last)
);

### tb/sv/tb_minhash_signature_engine_core.sv
`timescale 1ns / 100ps

module tb_minhash_signature_engine_core;

    import mhs_pkg::*;

    localparam int NH = DEF_HASH_COUNT;
    localparam int ITEM_TARGET = 450;

    typedef struct packed {
        logic [SIG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    value;
        logic                 fin;
    } sig_word_t;

    class minhash_scoreboard;
        logic [WORD_W-1:0] seeds [NH];
        logic [WORD_W-1:0] run_hash [NH];
        logic [WORD_W-1:0] sig_min [NH];
        bit                fresh_shingle;
        sig_word_t         expected_words [$];
        int                errors;
        int                words_checked;
        int                bytes_seen;
        int                shingles_done;
        int                readouts;
        int                clears;
        int                seed_writes;

        function new();
            for (int i = 0; i < NH; i++)
            begin
                seeds[i]    = '0;
                run_hash[i] = '0;
                sig_min[i]  = '1;
            end
            fresh_shingle = 1'b1;
        endfunction

        function logic [WORD_W-1:0] fold_byte(logic [WORD_W-1:0] h, logic [BYTE_W-1:0] b);
            logic [WORD_W-1:0] x;
            x = h ^ {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
            x = {x[WORD_W-ROT_LEFT-1:0], x[WORD_W-1:WORD_W-ROT_LEFT]};
            x = x * MIX_MUL;
            return x;
        endfunction

        function logic [WORD_W-1:0] finalize_hash(logic [WORD_W-1:0] h);
            logic [WORD_W-1:0] x;
            x = h ^ (h >> FIN_SHIFT_A);
            x = x * FIN_MUL;
            x = x ^ (x >> FIN_SHIFT_B);
            return x;
        endfunction

        function void apply_command(action_t act, logic [SIG_IDX_W-1:0] idx,
                                    logic [WORD_W-1:0] val, logic [BYTE_W-1:0] b,
                                    logic lb);
            logic [WORD_W-1:0] h;
            logic [WORD_W-1:0] f;
            sig_word_t         w;
            case (act)
                ACT_WRITE_SEED:
                begin
                    if (idx < NH)
                        seeds[idx] = val;
                    seed_writes++;
                end
                ACT_CLEAR_SIG:
                begin
                    for (int i = 0; i < NH; i++)
                        sig_min[i] = '1;
                    fresh_shingle = 1'b1;
                    clears++;
                end
                ACT_BYTE:
                begin
                    for (int i = 0; i < NH; i++)
                    begin
                        h = fresh_shingle ? seeds[i] : run_hash[i];
                        h = fold_byte(h, b);
                        run_hash[i] = h;
                        if (lb)
                        begin
                            f = finalize_hash(h);
                            if (f < sig_min[i])
                                sig_min[i] = f;
                        end
                    end
                    fresh_shingle = lb;
                    bytes_seen++;
                    if (lb)
                        shingles_done++;
                end
                default:
                begin
                    for (int i = 0; i < NH; i++)
                    begin
                        w.idx   = i[SIG_IDX_W-1:0];
                        w.value = sig_min[i];
                        w.fin   = (i == NH - 1);
                        expected_words = {expected_words, w};
                    end
                    readouts++;
                end
            endcase
        endfunction

        function void check_word(logic [SIG_IDX_W-1:0] idx, logic [WORD_W-1:0] val,
                                 logic fin);
            sig_word_t w;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected signature word idx=%0d value=%h last=%b",
                         $time, idx, val, fin);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (idx !== w.idx)
            begin
                $display("%0t: sig_index mismatch expected %0d actual %0d",
                         $time, w.idx, idx);
                errors++;
            end
            if (val !== w.value)
            begin
                $display("%0t: sig_value mismatch at index %0d expected %h actual %h",
                         $time, w.idx, w.value, val);
                errors++;
            end
            if (fin !== w.fin)
            begin
                $display("%0t: last mismatch at index %0d expected %b actual %b",
                         $time, w.idx, w.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    action_t              action;
    logic [SIG_IDX_W-1:0] seed_index;
    logic [WORD_W-1:0]    seed_value;
    logic [BYTE_W-1:0]    text_byte;
    logic                 last_byte;
    logic                 strobe;
    logic [SIG_IDX_W-1:0] sig_index;
    logic [WORD_W-1:0]    sig_value;
    logic                 last;

    minhash_scoreboard sb = new();
    int item_count = 0;
    int burst_left = 0;

    minhash_signature_engine_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .seed_index (seed_index),
        .seed_value (seed_value),
        .text_byte  (text_byte),
        .last_byte  (last_byte),
        .strobe     (strobe),
        .sig_index  (sig_index),
        .sig_value  (sig_value),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // accepted items and result words, both taken on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.apply_command(action, seed_index, seed_value, text_byte, last_byte);
            if (strobe)
                sb.check_word(sig_index, sig_value, last);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(action_t act, logic [SIG_IDX_W-1:0] idx,
                             logic [WORD_W-1:0] val, logic [BYTE_W-1:0] b, logic lb);
        int gap;
        if (burst_left == 0)
        begin
            // mostly short gaps, now and then one long enough to span a whole pass
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 12);
                default: gap = $urandom_range(1, 80);
            endcase
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        start      = 1'b1;
        action     = act;
        seed_index = idx;
        seed_value = val;
        text_byte  = b;
        last_byte  = lb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        item_count++;
    endtask

    task automatic send_seed(logic [SIG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        send_item(ACT_WRITE_SEED, idx, val, BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b, logic lb);
        send_item(ACT_BYTE, SIG_IDX_W'($urandom), $urandom, b, lb);
    endtask

    task automatic send_plain(action_t act);
        send_item(act, SIG_IDX_W'($urandom), $urandom, BYTE_W'($urandom), 1'($urandom));
    endtask

    // tokens of lower-case letters joined by single spaces, or raw bytes when noisy
    task automatic send_shingle(int ntok, bit noisy, bit finish);
        int tlen;
        for (int t = 0; t < ntok; t++)
        begin
            tlen = $urandom_range(1, 6);
            for (int k = 0; k < tlen; k++)
            begin
                if (noisy)
                    send_byte(BYTE_W'($urandom_range(0, 255)),
                              finish && t == ntok - 1 && k == tlen - 1);
                else
                    send_byte(BYTE_W'($urandom_range(97, 122)),
                              finish && t == ntok - 1 && k == tlen - 1);
            end
            if (t != ntok - 1)
                send_byte(8'h20, 1'b0);
        end
    endtask

    initial
    begin
        int r;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_WRITE_SEED;
        seed_index = '0;
        seed_value = '0;
        text_byte  = '0;
        last_byte  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every seed entry is written before any byte reads it
        send_seed('0, 32'h0000_0000);
        send_seed(SIG_IDX_W'(NH - 1), 32'hffff_ffff);
        for (int i = 1; i < NH - 1; i++)
            send_seed(SIG_IDX_W'(i), $urandom);

        // signature straight out of reset is all ones
        send_plain(ACT_READ_SIG);
        // byte extremes, sign extension on the top two
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b1);
        // one-byte shingle
        send_byte(8'h41, 1'b1);
        send_plain(ACT_READ_SIG);
        // readout in the middle of a shingle leaves it running
        send_byte(8'h61, 1'b0);
        send_byte(8'h20, 1'b0);
        send_plain(ACT_READ_SIG);
        send_byte(8'h62, 1'b1);
        send_plain(ACT_READ_SIG);
        // clear in the middle of a shingle drops the partial one
        send_byte(8'h63, 1'b0);
        send_plain(ACT_CLEAR_SIG);
        send_byte(8'h64, 1'b1);
        send_plain(ACT_READ_SIG);
        // seed rewrite while a shingle is open, then at its boundary
        send_byte(8'h65, 1'b0);
        send_seed('0, 32'hffff_ffff);
        send_byte(8'h66, 1'b1);
        send_seed(SIG_IDX_W'(NH - 1), 32'h0000_0000);
        send_byte(8'h67, 1'b1);
        send_plain(ACT_READ_SIG);

        while (item_count < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                send_shingle($urandom_range(1, 4), $urandom_range(0, 3) == 0, 1'b1);
            else if (r < 74)
            begin
                send_shingle($urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b0);
                if ($urandom_range(0, 1))
                    send_plain(ACT_CLEAR_SIG);
                else
                    send_plain(ACT_READ_SIG);
            end
            else if (r < 86)
                send_plain(ACT_READ_SIG);
            else if (r < 91)
                send_plain(ACT_CLEAR_SIG);
            else
                send_seed(SIG_IDX_W'($urandom), $urandom);
        end
        send_plain(ACT_READ_SIG);

        start = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (NH + 8) @(posedge clk);

        $display("run covered %0d bytes (%0d shingles closed), %0d seed writes, %0d clears",
                 sb.bytes_seen, sb.shingles_done, sb.seed_writes, sb.clears);
        $display("compared %0d signature words over %0d readouts, %0d mismatches",
                 sb.words_checked, sb.readouts, sb.errors);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
sv/mhs_pkg.sv
sv/minhash_signature_engine_core.sv
sv/mhs_checker.sv
tb/sv/tb_minhash_signature_engine_core.sv
